// File: rtl/mtsg_pkg.sv
package mtsg_pkg;

  localparam int MAX_TOP_K_DEF   = 8;
  localparam int MAX_EXPERTS_DEF = 128;

  localparam int ScoreW  = 16;
  localparam int ExpertW = 7;
  localparam int WeightW = 16;
  localparam int TopKW   = 4;
  localparam int LimitW  = 8;
  localparam int ExpW    = 33;  // Q1.32 value up to and including 1.0

  localparam logic [ExpW-1:0] ONE_Q32      = 33'h1_0000_0000;
  localparam logic [31:0]     EXP_NEG1_Q32 = 32'd1580030168;
  localparam logic [3:0]      HORNER_TERMS = 4'd12;

  // Register indexes (bit 2 of the byte address)
  localparam logic REG_TOP_K = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic                     last_score;
  } in_t;

  typedef struct packed {
    logic [ExpertW-1:0] expert;
    logic [WeightW-1:0] weight;
    logic               last_pick;
  } out_t;

  typedef struct packed {
    logic                     valid;
    logic signed [ScoreW-1:0] score;
    logic [ExpertW-1:0]       expert;
    logic [ExpW-1:0]          e;
  } cell_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROT,
    OP_CLR
  } cell_op_e;

  typedef struct packed {
    cell_op_e                 op;
    logic                     ins;
    logic signed [ScoreW-1:0] score;
    logic [ExpertW-1:0]       expert;
  } cell_ctrl_t;

  // floor(p / k) for the Horner divisors: multiply by m = ceil(2^(32+l) / k) with
  // l = ceil(log2 k) and keep the bits above 32 + l; exact for every 32-bit p
  function automatic logic [31:0] div_const(input logic [31:0] p, input logic [3:0] k);
    logic [32:0] m;
    logic [2:0]  l;
    logic [64:0] prod;
    logic [32:0] hi;
    case (k)
      4'd1:    begin m = 33'h1_0000_0000;  l = 3'd0; end
      4'd2:    begin m = 33'h1_0000_0000;  l = 3'd1; end
      4'd3:    begin m = 33'd5726623062;   l = 3'd2; end
      4'd4:    begin m = 33'h1_0000_0000;  l = 3'd2; end
      4'd5:    begin m = 33'd6871947674;   l = 3'd3; end
      4'd6:    begin m = 33'd5726623062;   l = 3'd3; end
      4'd7:    begin m = 33'd4908534053;   l = 3'd3; end
      4'd8:    begin m = 33'h1_0000_0000;  l = 3'd3; end
      4'd9:    begin m = 33'd7635497416;   l = 3'd4; end
      4'd10:   begin m = 33'd6871947674;   l = 3'd4; end
      4'd11:   begin m = 33'd6247225158;   l = 3'd4; end
      4'd12:   begin m = 33'd5726623062;   l = 3'd4; end
      default: begin m = 33'h1_0000_0000;  l = 3'd0; end
    endcase
    prod = 65'(p) * 65'(m);
    hi   = prod[64:32] >> l;
    return hi[31:0];
  endfunction

endpackage

// File: rtl/moe_topk_softmax_gate.sv
// On the item marked last the block stalls its input for the emission: an exponential
// for each held entry, then a division for each emitted pick.
// Throughput: one non-final score per cycle, set by the insertion chain.
// Reset: asynchronous, active low; registers return to top_k 8, expert_limit 128,
// the chain is emptied and the arrival counter cleared.
module moe_topk_softmax_gate #(
  parameter int MaxTopK    = mtsg_pkg::MAX_TOP_K_DEF,
  parameter int MaxExperts = mtsg_pkg::MAX_EXPERTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // score request channel
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mtsg_pkg::in_t  in_data_i,
  // pick channel
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mtsg_pkg::out_t out_data_o,
  // register port
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import mtsg_pkg::*;

  localparam int KW   = $clog2(MaxTopK + 1);
  localparam int AW   = $clog2(MaxExperts + 1);
  localparam int RW   = (MaxTopK > 1) ? $clog2(MaxTopK) : 1;
  localparam int SumW = ExpW + $clog2(MaxTopK + 1);
  localparam int NumW = SumW + WeightW + 1;

  localparam logic [2:0] S_IN   = 3'd0;
  localparam logic [2:0] S_MAX  = 3'd1;
  localparam logic [2:0] S_EXP  = 3'd2;
  localparam logic [2:0] S_EXPW = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DIVW = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]               st_q;
  logic [TopKW-1:0]         top_k_q;
  logic [LimitW-1:0]        lim_q;
  logic [AW-1:0]            arr_q;
  logic [KW-1:0]            n_q;
  logic [KW-1:0]            pick_q;
  logic [RW-1:0]            rot_q;
  logic signed [ScoreW-1:0] max_q;
  logic [SumW-1:0]          sum_q;
  out_t                     out_q;

  logic [KW-1:0] k_eff;
  logic [AW-1:0] lim_eff;
  logic          in_acc, out_acc, rot_last;
  cell_ctrl_t    ctrl;
  cell_t         cells [MaxTopK];
  logic          keep  [MaxTopK];
  logic [MaxTopK-1:0] valid_vec;
  cell_t         wrap;
  logic [KW-1:0] cnt_valid;
  logic          exp_skip;

  logic                exp_start, exp_done;
  logic [ExpW-1:0]     exp_v;
  logic                div_start, div_done;
  logic [WeightW-1:0]  div_q;

  // ---------------------------------------------------------------- registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_k_q <= TopKW'(8);
      lim_q   <= LimitW'(128);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_TOP_K: top_k_q <= pwdata[TopKW-1:0];
        REG_LIMIT: lim_q   <= pwdata[LimitW-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TOP_K: prdata = 32'(top_k_q);
      REG_LIMIT: prdata = 32'(lim_q);
      default:   prdata = '0;
    endcase
  end

  // clamp the registers to what the hardware holds
  assign k_eff   = (int'(top_k_q) > MaxTopK) ? KW'(MaxTopK) : KW'(top_k_q);
  assign lim_eff = (int'(lim_q) > MaxExperts) ? AW'(MaxExperts) : AW'(lim_q);

  // ---------------------------------------------------------------- handshake
  assign in_stall_o  = (st_q != S_IN);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (st_q == S_OUT);
  assign out_data_o  = out_q;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign rot_last    = (rot_q == RW'(MaxTopK - 1));

  // ---------------------------------------------------------------- cell chain
  // Insert shifts the tail down one cell; rotate moves every cell toward the
  // head and feeds the head back in at the tail, with its exponential filled in
  // during the exp pass. Entries past top_k (left over when top_k drops without
  // a later insertion) are rotated through without an exponential.
  always_comb begin
    ctrl.op     = OP_HOLD;
    ctrl.ins    = (arr_q < lim_eff);
    ctrl.score  = in_data_i.score;
    ctrl.expert = ExpertW'(arr_q);
    wrap        = cells[0];
    if (st_q == S_EXPW) wrap.e = exp_v;
    case (st_q)
      S_IN:    if (in_acc) ctrl.op = OP_INSERT;
      S_EXP:   if (exp_skip) ctrl.op = OP_ROT;
      S_EXPW:  if (exp_done) ctrl.op = OP_ROT;
      S_OUT: begin
        if (out_acc) ctrl.op = out_q.last_pick ? OP_CLR : OP_ROT;
      end
      S_DIV:   if (n_q == '0) ctrl.op = OP_CLR;
      default: ;
    endcase
  end

  for (genvar i = 0; i < MaxTopK; i++) begin : g_cell
    mtsg_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .en_i        (i < int'(k_eff)),
      .prev_keep_i ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
      .prev_i      (cells[(i == 0) ? 0 : i - 1]),
      .next_i      ((i == MaxTopK - 1) ? wrap : cells[(i == MaxTopK - 1) ? 0 : i + 1]),
      .data_o      (cells[i]),
      .keep_o      (keep[i])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  assign cnt_valid = KW'($countones(valid_vec));
  assign exp_skip  = !cells[0].valid || (KW'(rot_q) >= k_eff);

  // ---------------------------------------------------------------- math units
  assign exp_start = (st_q == S_EXP) && !exp_skip;
  assign div_start = (st_q == S_DIV) && (n_q != '0);

  mtsg_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start),
    .d_i     (ScoreW'(max_q - cells[0].score)),
    .done_o  (exp_done),
    .v_o     (exp_v)
  );

  mtsg_div #(
    .NumW (NumW),
    .DenW (SumW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (NumW'({cells[0].e, WeightW'(0)}) + NumW'(sum_q >> 1)),
    .den_i   (sum_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IN;
      arr_q  <= '0;
      rot_q  <= '0;
      pick_q <= '0;
    end else begin
      case (st_q)
        S_IN: begin
          if (in_acc) begin
            if (arr_q < AW'(MaxExperts)) arr_q <= arr_q + AW'(1);
            if (in_data_i.last_score) st_q <= S_MAX;
          end
        end
        S_MAX: begin
          rot_q <= '0;
          st_q  <= S_EXP;
        end
        S_EXP: begin
          if (exp_skip) begin
            rot_q <= rot_q + RW'(1);
            if (rot_last) st_q <= S_DIV;
          end else begin
            st_q <= S_EXPW;
          end
        end
        S_EXPW: begin
          if (exp_done) begin
            rot_q <= rot_q + RW'(1);
            st_q  <= rot_last ? S_DIV : S_EXP;
          end
        end
        S_DIV: begin
          if (n_q == '0) begin
            arr_q <= '0;
            st_q  <= S_IN;
          end else begin
            st_q <= S_DIVW;
          end
        end
        S_DIVW: if (div_done) st_q <= S_OUT;
        S_OUT: begin
          if (out_acc) begin
            pick_q <= pick_q + KW'(1);
            if (out_q.last_pick) begin
              arr_q  <= '0;
              pick_q <= '0;
              st_q   <= S_IN;
            end else begin
              st_q <= S_DIV;
            end
          end
        end
        default: st_q <= S_IN;
      endcase
    end
  end

  // payload side: max, count, running sum, pick register
  always_ff @(posedge clk_i) begin
    if (st_q == S_MAX) begin
      max_q <= cells[0].score;
      n_q   <= (cnt_valid > k_eff) ? k_eff : cnt_valid;
      sum_q <= '0;
    end
    if (st_q == S_EXPW && exp_done) sum_q <= sum_q + SumW'(exp_v);
    if (st_q == S_DIVW && div_done) begin
      out_q.expert    <= cells[0].expert;
      out_q.weight    <= div_q;
      out_q.last_pick <= (pick_q == n_q - KW'(1));
    end
  end

endmodule

// File: rtl/mtsg_cell.sv
module mtsg_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtsg_pkg::cell_ctrl_t ctrl_i,
  input  logic               en_i,
  input  logic               prev_keep_i,
  input  mtsg_pkg::cell_t    prev_i,
  input  mtsg_pkg::cell_t    next_i,
  output mtsg_pkg::cell_t    data_o,
  output logic               keep_o
);
  import mtsg_pkg::*;

  logic  valid_q, valid_d;
  cell_t pay_q, pay_d;

  // hold position when this entry beats the new score (ties stay ahead)
  assign keep_o = valid_q && en_i && (pay_q.score >= ctrl_i.score);

  always_comb begin
    valid_d = valid_q;
    pay_d   = pay_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (ctrl_i.ins) begin
          if (!en_i) begin
            valid_d = 1'b0;
          end else if (!keep_o) begin
            if (prev_keep_i) begin
              valid_d       = 1'b1;
              pay_d.score   = ctrl_i.score;
              pay_d.expert  = ctrl_i.expert;
            end else begin
              valid_d = prev_i.valid;
              pay_d   = prev_i;
            end
          end
        end
      end
      OP_ROT: begin
        valid_d = next_i.valid;
        pay_d   = next_i;
      end
      OP_CLR:  valid_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  always_comb begin
    data_o       = pay_q;
    data_o.valid = valid_q;
  end

endmodule

// File: rtl/mtsg_exp.sv
module mtsg_exp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mtsg_pkg::ScoreW-1:0] d_i,
  output logic                      done_o,
  output logic [mtsg_pkg::ExpW-1:0] v_o
);
  import mtsg_pkg::*;

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_MUL  = 2'd1;
  localparam logic [1:0] E_DIV  = 2'd2;
  localparam logic [1:0] E_POW  = 2'd3;

  logic [1:0]      st_q;
  logic [31:0]     x_q;
  logic [ExpW-1:0] v_q;
  logic [31:0]     p_q;
  logic [3:0]      k_q;
  logic [7:0]      n_q;
  logic [64:0]     prod_h;
  logic [64:0]     prod_p;

  assign prod_h = x_q * v_q;
  assign prod_p = v_q * EXP_NEG1_Q32;
  assign done_o = (st_q == E_POW) && ((n_q == '0) || (v_q == '0));
  assign v_o    = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= E_IDLE;
    end else begin
      case (st_q)
        E_IDLE:  if (start_i) st_q <= E_MUL;
        E_MUL:   st_q <= E_DIV;
        E_DIV:   st_q <= (k_q == 4'd1) ? E_POW : E_MUL;
        E_POW:   if (done_o) st_q <= E_IDLE;
        default: st_q <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      E_IDLE: begin
        x_q <= {d_i[7:0], 24'd0};
        n_q <= d_i[15:8];
        v_q <= ONE_Q32;
        k_q <= HORNER_TERMS;
      end
      E_MUL: p_q <= prod_h[63:32];
      E_DIV: begin
        v_q <= ONE_Q32 - {1'b0, div_const(p_q, k_q)};
        k_q <= k_q - 4'd1;
      end
      E_POW: begin
        if (!done_o) begin
          v_q <= {1'b0, prod_p[63:32]};
          n_q <= n_q - 8'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/mtsg_div.sv
module mtsg_div #(
  parameter int NumW = 53,
  parameter int DenW = 36
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [NumW-1:0]             num_i,
  input  logic [DenW-1:0]             den_i,
  output logic                        done_o,
  output logic [mtsg_pkg::WeightW-1:0] q_o
);
  import mtsg_pkg::*;

  localparam int QW = WeightW + 1;

  logic            busy_q, done_q;
  logic [NumW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [4:0]      b_q;
  logic [QW-1:0]   q_q;
  logic [NumW-1:0] den_sh;

  assign den_sh = NumW'(den_q) << b_q;
  assign done_o = done_q;
  assign q_o    = q_q[WeightW] ? {WeightW{1'b1}} : q_q[WeightW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (b_q == '0);
      if (start_i) busy_q <= 1'b1;
      else if (b_q == '0) busy_q <= 1'b0;
    end
  end

  // one quotient bit per cycle, largest first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      b_q   <= 5'(WeightW);
      q_q   <= '0;
    end else if (busy_q) begin
      if (rem_q >= den_sh) begin
        rem_q     <= rem_q - den_sh;
        q_q[b_q]  <= 1'b1;
      end
      if (b_q != '0) b_q <= b_q - 5'd1;
    end
  end

endmodule

// File: rtl/mtsg_chk.sv
module mtsg_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input mtsg_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input mtsg_pkg::out_t out_data_o
);
  import mtsg_pkg::*;

  // a stalled pick holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("pick changed under stall");

  // no score is taken while picks are being emitted
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open during emission");

  // the final score closes the input for emission
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_score |=> in_stall_o)
    else $error("input open after final score");

  // the final pick ends the run
  a_last_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.last_pick |=> !out_valid_o)
    else $error("pick after final pick");

endmodule

bind moe_topk_softmax_gate mtsg_chk u_mtsg_chk (.*);
